/* sv/ste_pkg.sv */
// Shared types and constants for the session table with expiry.
// Used by the interfaces, the slot store, the top level and the checker.
// No dependencies.
`default_nettype none

package ste_pkg;

  typedef enum logic [1:0] {
    ACT_CREATE     = 2'd0,
    ACT_CHECK      = 2'd1,
    ACT_INVALIDATE = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_NONE = 2'd1,
    RES_OLD  = 2'd2
  } res_e;

  localparam int TOK_W   = 64;
  localparam int TIME_W  = 32;
  localparam int REG_W   = 24;
  localparam int IDX_W   = 1;
  localparam int SLOT_W  = 4;

  localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
  localparam logic [IDX_W-1:0] REG_MAX_AGE      = 1'd1;

  localparam logic [REG_W-1:0] IDLE_TIMEOUT_RST = 24'd900;
  localparam logic [REG_W-1:0] MAX_AGE_RST      = 24'd86400;

  typedef struct packed {
    logic [TOK_W-1:0]  tok_hi;
    logic [TOK_W-1:0]  tok_lo;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] issue;
  } entry_t;

endpackage

`default_nettype wire

/* sv/ste_intf.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on ste_pkg for field widths.
`default_nettype none

interface ste_req_if
  import ste_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [TOK_W-1:0]  token_high;
  logic [TOK_W-1:0]  token_low;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, action, token_high, token_low, now_seconds, input ready);
  modport sink   (input valid, action, token_high, token_low, now_seconds, output ready);
endinterface

interface ste_rsp_if
  import ste_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        result_code;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, result_code, slot_index, input ready);
  modport sink   (input valid, result_code, slot_index, output ready);
endinterface

`default_nettype wire

/* sv/ste_store.sv */
// Slot store: one synchronous memory of session entries with a registered read port.
// Per-entry valid bits make unwritten slots read as all zero after reset.
// Depends on ste_pkg.
`default_nettype none

module ste_store
  import ste_pkg::*;
#(
  parameter int SESSIONS = 16,
  localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output      entry_t        rd_entry_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire entry_t        wr_entry_i
);

  entry_t                mem_q [SESSIONS];
  entry_t                rd_data_q;
  logic                  rd_vld_q;
  logic [SESSIONS-1:0]   vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // never-written slot reads as the reset value
  assign rd_entry_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* sv/session_table_with_expiry_top.sv */
// Session table with expiry: top level with request scan and write-back control.
// Depends on ste_pkg, ste_intf (request/response channels) and ste_store.
//
// Usage:
//   req_i carries action, 128-bit token (two halves) and current time; rsp_o
//   returns one result_code and slot_index per request. Transfers complete when
//   valid and ready are both high. Config writes (cfg_we_i, cfg_idx_i,
//   cfg_data_i) set idle_timeout and max_session_age; issue them while idle.
// Timing:
//   One request at a time. The store is read one slot per cycle, so a request
//   streams all slots through the registered read port, then passes through
//   the write-back state (ST_WB) and the output load state (ST_DONE) before
//   its response is valid. The next request can be taken once the previous
//   one has loaded its result.
// Stall:
//   The response sits in an output register; a new request is accepted and
//   processed while it waits, and its result is held until the register frees.
// Reset:
//   All slots read as zero (expired), registers return to 900 and 86400.
`default_nettype none

module session_table_with_expiry_top
  import ste_pkg::*;
#(
  parameter int SESSIONS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ste_req_if.sink               req_i,
  ste_rsp_if.source             rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0] cfg_data_i
);

  localparam int AW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CW    = AW + 1;
  localparam int SLW   = (AW > SLOT_W) ? AW : SLOT_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WB   = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [REG_W-1:0]  idle_q, max_age_q;

  // request latch
  act_e              act_q;
  logic [TOK_W-1:0]  tok_hi_q, tok_lo_q;
  logic [TIME_W-1:0] now_q;

  // scan pipeline
  logic [CW-1:0]     rd_cnt_q;
  logic              pv_q;
  logic [AW-1:0]     pidx_q;
  logic              rd_en;
  entry_t            rd_entry;

  // scan results
  logic              found_q;
  logic [AW-1:0]     slot_q;
  logic [TIME_W-1:0] oldest_q;
  res_e              chk_code_q;
  logic [TIME_W-1:0] hit_issue_q;

  // write-back and result
  logic              wr_en;
  entry_t            wr_entry;
  res_e              res_code_d;
  logic [AW-1:0]     res_slot_d;
  res_e              res_code_q;
  logic [AW-1:0]     res_slot_q;
  logic              out_valid_q;
  logic [1:0]        out_code_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_free;
  logic [SLW-1:0]    slot_ext;

  logic              in_xfer;
  logic              tok_eq, live, is_old;
  logic [TIME_W-1:0] age;
  logic [TIME_W:0]   exp_sum;
  logic [TIME_W-1:0] exp_sat;

  assign in_xfer  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign rd_en = (state_q == ST_SCAN) && (rd_cnt_q != CW'(SESSIONS));

  ste_store #(
    .SESSIONS (SESSIONS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_cnt_q[AW-1:0]),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_entry_i (wr_entry)
  );

  // per-slot evaluation of the entry coming out of the store
  assign tok_eq = (rd_entry.tok_hi == tok_hi_q) && (rd_entry.tok_lo == tok_lo_q);
  assign live   = rd_entry.expiry > now_q;
  assign age    = (now_q >= rd_entry.issue) ? (now_q - rd_entry.issue) : '0;
  assign is_old = age > TIME_W'(max_age_q);

  assign exp_sum = {1'b0, now_q} + (TIME_W + 1)'(idle_q);
  assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  always_comb begin
    wr_en      = 1'b0;
    wr_entry   = '0;
    res_code_d = RES_NONE;
    res_slot_d = '0;
    if (state_q == ST_WB) begin
      case (act_q)
        ACT_CREATE: begin
          wr_en      = 1'b1;
          wr_entry   = '{tok_hi: tok_hi_q, tok_lo: tok_lo_q, expiry: exp_sat, issue: now_q};
          res_code_d = RES_OK;
          res_slot_d = slot_q;
        end
        ACT_CHECK: begin
          if (found_q) begin
            res_code_d = chk_code_q;
            res_slot_d = slot_q;
            if (chk_code_q == RES_OK) begin
              wr_en    = 1'b1;
              wr_entry = '{tok_hi: tok_hi_q, tok_lo: tok_lo_q, expiry: exp_sat,
                           issue: hit_issue_q};
            end
          end
        end
        ACT_INVALIDATE: begin
          if (found_q) begin
            wr_en      = 1'b1;
            res_code_d = RES_OK;
            res_slot_d = slot_q;
          end
        end
        default: begin
          res_code_d = RES_NONE;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_SCAN;
      ST_SCAN: if (pv_q && (pidx_q == AW'(SESSIONS - 1))) state_d = ST_WB;
      ST_WB:   state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idle_q      <= IDLE_TIMEOUT_RST;
      max_age_q   <= MAX_AGE_RST;
      rd_cnt_q    <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IDLE_TIMEOUT: idle_q    <= cfg_data_i;
          REG_MAX_AGE:      max_age_q <= cfg_data_i;
          default: ;
        endcase
      end
      pv_q <= rd_en;
      if (in_xfer) begin
        rd_cnt_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (rd_en) rd_cnt_q <= rd_cnt_q + CW'(1);
        if (pv_q) begin
          case (act_q)
            ACT_CREATE:     if (!found_q && (rd_entry.expiry <= now_q)) found_q <= 1'b1;
            ACT_CHECK:      if (!found_q && live && tok_eq) found_q <= 1'b1;
            ACT_INVALIDATE: if (!found_q && tok_eq) found_q <= 1'b1;
            default: ;
          endcase
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q    <= act_e'(req_i.action);
      tok_hi_q <= req_i.token_high;
      tok_lo_q <= req_i.token_low;
      now_q    <= req_i.now_seconds;
      slot_q   <= '0;
    end
    pidx_q <= rd_cnt_q[AW-1:0];
    if (pv_q && !found_q) begin
      case (act_q)
        ACT_CREATE: begin
          if (rd_entry.expiry <= now_q) begin
            slot_q <= pidx_q;
          end else if ((pidx_q == '0) || (rd_entry.expiry < oldest_q)) begin
            // earliest expiry so far, lowest index on ties
            oldest_q <= rd_entry.expiry;
            slot_q   <= pidx_q;
          end
        end
        ACT_CHECK: begin
          if (live && tok_eq) begin
            slot_q      <= pidx_q;
            hit_issue_q <= rd_entry.issue;
            chk_code_q  <= is_old ? RES_OLD : RES_OK;
          end
        end
        ACT_INVALIDATE: begin
          if (tok_eq) slot_q <= pidx_q;
        end
        default: ;
      endcase
    end
    if (state_q == ST_WB) begin
      res_code_q <= res_code_d;
      res_slot_q <= res_slot_d;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_code_q <= res_code_q;
      out_slot_q <= slot_ext[SLOT_W-1:0];
    end
  end

  assign slot_ext = SLW'(res_slot_q);

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_code = out_code_q;
  assign rsp_o.slot_index  = out_slot_q;

endmodule

`default_nettype wire

/* sv/ste_checker.sv */
// Port-level checker for the session table top level, attached by bind.
// Depends on ste_pkg and session_table_with_expiry_top.
`default_nettype none

module ste_checker
  import ste_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [1:0]        out_code_i,
  input wire logic [SLOT_W-1:0] out_slot_i
);

  // a stalled response keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_code_i) && $stable(out_slot_i))
    else $error("response dropped or changed while stalled");

  // only defined result codes leave the block
  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_code_i == RES_OK) || (out_code_i == RES_NONE) ||
                    (out_code_i == RES_OLD))
    else $error("undefined result code");

  // one request in flight: busy right after a request transfer
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one in flight");

  // a fresh response is loaded only at the end of processing
  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("response appeared without a request in flight");

endmodule

bind session_table_with_expiry_top ste_checker u_ste_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_code_i  (rsp_o.result_code),
  .out_slot_i  (rsp_o.slot_index)
);

`default_nettype wire
